### sv/iol_pkg.sv
package iol_pkg;

    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;
    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [LEN_W-1:0]  t_len;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_READ
    } t_state;

endpackage

### sv/indexed_ordered_list.sv
// Channel   Direction  Handshake           Payload
// request   in         start, busy         i_action, i_position, i_new_item
// result    out        o_done (strobe)     o_accepted, o_read_value, o_length, o_empty_res
//
// A rejected request, an append, an insert at the tail and a removal of the last
// item complete in the cycle after they are taken. A read waits in ST_READ for the
// registered memory read data. An insert or a removal that moves entries runs in
// ST_MOVE; the entries move one per cycle through the single read and write ports of the entry memory.
// Reset is synchronous and active low; it empties the list, memory contents are kept.
// The result is shown for one cycle and cannot be stalled; a new request is taken
// in the same cycle.
module indexed_ordered_list #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [4:0]         i_position,
    input  logic signed [31:0] i_new_item,
    output logic               o_done,
    output logic               o_accepted,
    output logic signed [31:0] o_read_value,
    output logic [4:0]         o_length,
    output logic               o_empty_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;

    typedef logic [ITEM_WIDTH-1:0] t_entry;
    typedef logic [AW-1:0]         t_addr;
    typedef logic [CW-1:0]         t_cnt;
    typedef logic [PW-1:0]         t_cmp;

    iol_pkg::t_state  r_state, n_state;
    iol_pkg::t_action r_op, n_op;
    t_entry           r_item, n_item;
    t_addr            r_src, n_src;
    t_addr            r_dst, n_dst;
    t_cnt             r_left, n_left;
    logic             r_rvalid, n_rvalid;
    t_cnt             r_count, n_count;
    logic             r_done, n_done;
    logic             r_accepted, n_accepted;
    iol_pkg::t_word   r_read_value, n_read_value;
    iol_pkg::t_len    r_length, n_length;
    logic             r_empty, n_empty;

    logic             ram_we, ram_re;
    t_addr            ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;

    iol_pkg::t_action act;
    t_cmp             pos_c, cnt_c;
    t_cnt             moves;
    logic             take, full, ok;

    iol_ram #(
        .WIDTH(ITEM_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign act   = iol_pkg::t_action'(i_action);
    assign pos_c = t_cmp'(i_position);
    assign cnt_c = t_cmp'(r_count);
    assign full  = (r_count == t_cnt'(DEPTH));
    assign take  = start && (r_state == iol_pkg::ST_IDLE);

    always_comb begin
        case (act)
            iol_pkg::ACT_APPEND: ok = !full;
            iol_pkg::ACT_INSERT: ok = !full && (pos_c <= cnt_c);
            default:             ok = (pos_c < cnt_c);
        endcase
        if (act == iol_pkg::ACT_INSERT) begin
            moves = t_cnt'(cnt_c - pos_c);
        end else begin
            moves = t_cnt'(cnt_c - pos_c - t_cmp'(1));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            iol_pkg::ST_IDLE: begin
                if (take && ok) begin
                    if (act == iol_pkg::ACT_READ) begin
                        n_state = iol_pkg::ST_READ;
                    end else if ((act == iol_pkg::ACT_INSERT || act == iol_pkg::ACT_REMOVE)
                                 && moves != '0) begin
                        n_state = iol_pkg::ST_MOVE;
                    end
                end
            end
            iol_pkg::ST_MOVE: begin
                if (r_left == '0 && !r_rvalid) begin
                    n_state = iol_pkg::ST_IDLE;
                end
            end
            iol_pkg::ST_READ: n_state = iol_pkg::ST_IDLE;
            default:          n_state = iol_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy         = (r_state != iol_pkg::ST_IDLE);
        n_op         = r_op;
        n_item       = r_item;
        n_src        = r_src;
        n_dst        = r_dst;
        n_left       = r_left;
        n_rvalid     = 1'b0;
        n_count      = r_count;
        n_done       = 1'b0;
        n_accepted   = r_accepted;
        n_read_value = r_read_value;
        n_length     = r_length;
        n_empty      = r_empty;
        ram_we       = 1'b0;
        ram_waddr    = r_dst;
        ram_wdata    = r_item;
        ram_re       = 1'b0;
        ram_raddr    = r_src;

        case (r_state)
            iol_pkg::ST_IDLE: begin
                if (take) begin
                    n_op   = act;
                    n_item = t_entry'(i_new_item);
                    n_read_value = '0;
                    n_accepted   = ok;
                    if (!ok) begin
                        n_done = 1'b1;
                    end else begin
                        case (act)
                            iol_pkg::ACT_APPEND: begin
                                ram_we    = 1'b1;
                                ram_waddr = t_addr'(r_count);
                                ram_wdata = t_entry'(i_new_item);
                                n_count   = r_count + t_cnt'(1);
                                n_done    = 1'b1;
                            end
                            iol_pkg::ACT_INSERT: begin
                                if (moves == '0) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = t_addr'(pos_c);
                                    ram_wdata = t_entry'(i_new_item);
                                    n_count   = r_count + t_cnt'(1);
                                    n_done    = 1'b1;
                                end else begin
                                    n_src  = t_addr'(r_count - t_cnt'(1));
                                    n_dst  = t_addr'(r_count);
                                    n_left = moves;
                                end
                            end
                            iol_pkg::ACT_REMOVE: begin
                                if (moves == '0) begin
                                    n_count = r_count - t_cnt'(1);
                                    n_done  = 1'b1;
                                end else begin
                                    n_src  = t_addr'(pos_c + t_cmp'(1));
                                    n_dst  = t_addr'(pos_c);
                                    n_left = moves;
                                end
                            end
                            default: begin
                                ram_re    = 1'b1;
                                ram_raddr = t_addr'(pos_c);
                            end
                        endcase
                    end
                end
            end
            iol_pkg::ST_MOVE: begin
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_src;
                    n_left    = r_left - t_cnt'(1);
                    n_rvalid  = 1'b1;
                    if (r_op == iol_pkg::ACT_INSERT) begin
                        n_src = r_src - t_addr'(1);
                    end else begin
                        n_src = r_src + t_addr'(1);
                    end
                end
                if (r_rvalid) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dst;
                    ram_wdata = ram_rdata;
                    if (r_op == iol_pkg::ACT_INSERT) begin
                        n_dst = r_dst - t_addr'(1);
                    end else begin
                        n_dst = r_dst + t_addr'(1);
                    end
                end
                if (r_left == '0 && !r_rvalid) begin
                    n_done = 1'b1;
                    if (r_op == iol_pkg::ACT_INSERT) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_dst;
                        ram_wdata = r_item;
                        n_count   = r_count + t_cnt'(1);
                    end else begin
                        n_count = r_count - t_cnt'(1);
                    end
                end
            end
            iol_pkg::ST_READ: begin
                n_done       = 1'b1;
                n_read_value = iol_pkg::t_word'(ram_rdata);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase

        if (n_done) begin
            n_length = iol_pkg::t_len'(n_count);
            n_empty  = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= iol_pkg::ST_IDLE;
            r_count  <= '0;
            r_rvalid <= 1'b0;
            r_done   <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rvalid <= n_rvalid;
            r_done   <= n_done;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_item       <= n_item;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_accepted   <= n_accepted;
        r_read_value <= n_read_value;
        r_length     <= n_length;
        r_empty      <= n_empty;
    end

    assign o_done       = r_done;
    assign o_accepted   = r_accepted;
    assign o_read_value = r_read_value;
    assign o_length     = r_length;
    assign o_empty_res  = r_empty;

`ifndef SYNTHESIS
    a_done_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == iol_pkg::ST_IDLE))
        else $error("Result strobe while a transaction is still in progress.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(DEPTH))
        else $error("Item count exceeds the list depth.");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("Entry memory read and written at the same address.");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_accepted) |-> (r_read_value == '0))
        else $error("Rejected transaction returns a nonzero read value.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(n_done))
        else $error("Item count changed without a completed transaction.");
`endif

endmodule

### sv/iol_ram.sv
module iol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
